// File: hdl/cnfp_pkg.sv
// shared types and constants for the chinese numeral to fixed point core
// no dependencies
package cnfp_pkg;

    localparam int CP_W   = 21;
    localparam int SUM_W  = 11;
    localparam int FRAC_W = 7;
    localparam int AMT_W  = 14;
    localparam int MAG_W  = 17;
    localparam int VAL_W  = 18;

    localparam logic [CP_W-1:0] CP_MINUS    = 21'h08D1F;
    localparam logic [CP_W-1:0] CP_TEN      = 21'h05341;
    localparam logic [CP_W-1:0] CP_HUNDRED  = 21'h0767E;
    localparam logic [CP_W-1:0] CP_THOUSAND = 21'h05343;
    localparam logic [CP_W-1:0] CP_DOT_A    = 21'h070B9;
    localparam logic [CP_W-1:0] CP_DOT_B    = 21'h03002;
    localparam logic [CP_W-1:0] CP_ZERO_A   = 21'h096F6;
    localparam logic [CP_W-1:0] CP_ZERO_B   = 21'h03007;
    localparam logic [CP_W-1:0] CP_ONE      = 21'h04E00;
    localparam logic [CP_W-1:0] CP_TWO      = 21'h04E8C;
    localparam logic [CP_W-1:0] CP_THREE    = 21'h04E09;
    localparam logic [CP_W-1:0] CP_FOUR     = 21'h056DB;
    localparam logic [CP_W-1:0] CP_FIVE     = 21'h04E94;
    localparam logic [CP_W-1:0] CP_SIX      = 21'h0516D;
    localparam logic [CP_W-1:0] CP_SEVEN    = 21'h04E03;
    localparam logic [CP_W-1:0] CP_EIGHT    = 21'h0516B;
    localparam logic [CP_W-1:0] CP_NINE     = 21'h04E5D;

    localparam logic [SUM_W-1:0] INT_LIMIT = 11'd1000;
    localparam logic [SUM_W-1:0] SUM_SAT   = 11'd1001;

    localparam logic [1:0] MULT_NONE     = 2'd0;
    localparam logic [1:0] MULT_TEN      = 2'd1;
    localparam logic [1:0] MULT_HUNDRED  = 2'd2;
    localparam logic [1:0] MULT_THOUSAND = 2'd3;

    localparam logic [2:0] PH_SEEK  = 3'd0;
    localparam logic [2:0] PH_MINUS = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_FRAC  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic [1:0] mult;
        logic       is_dot;
        logic       is_minus;
    } cnfp_class_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
    } cnfp_result_t;

endpackage

// File: hdl/cnfp_char_if.sv
// input channel: one code point item with its end-of-string mark
// depends on cnfp_pkg
interface cnfp_char_if;
    logic                       valid;
    logic                       ready;
    logic [cnfp_pkg::CP_W-1:0]  code_point;
    logic                       last_char;

    modport source (output valid, output code_point, output last_char, input ready);
    modport sink (input valid, input code_point, input last_char, output ready);
endinterface

// File: hdl/cnfp_result_if.sv
// output channel: one parsed value item with its status
// depends on cnfp_pkg
interface cnfp_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [cnfp_pkg::VAL_W-1:0]  value_hundredths;
    logic [1:0]                         status;

    modport source (output valid, output value_hundredths, output status, input ready);
    modport sink (input valid, input value_hundredths, input status, output ready);
endinterface

// File: hdl/cnfp_classify.sv
// code point decoder: digit value, multiplier, dot and minus flags
// depends on cnfp_pkg
module cnfp_classify (
    input  logic [cnfp_pkg::CP_W-1:0] code_point,
    output cnfp_pkg::cnfp_class_t     cls
);

    always_comb
    begin
        cls = '0;
        unique case (code_point)
            cnfp_pkg::CP_ZERO_A, cnfp_pkg::CP_ZERO_B:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd0;
            end
            cnfp_pkg::CP_ONE:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd1;
            end
            cnfp_pkg::CP_TWO:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd2;
            end
            cnfp_pkg::CP_THREE:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd3;
            end
            cnfp_pkg::CP_FOUR:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd4;
            end
            cnfp_pkg::CP_FIVE:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd5;
            end
            cnfp_pkg::CP_SIX:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd6;
            end
            cnfp_pkg::CP_SEVEN:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd7;
            end
            cnfp_pkg::CP_EIGHT:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd8;
            end
            cnfp_pkg::CP_NINE:
            begin
                cls.is_digit = 1'b1;
                cls.digit    = 4'd9;
            end
            cnfp_pkg::CP_TEN:      cls.mult = cnfp_pkg::MULT_TEN;
            cnfp_pkg::CP_HUNDRED:  cls.mult = cnfp_pkg::MULT_HUNDRED;
            cnfp_pkg::CP_THOUSAND: cls.mult = cnfp_pkg::MULT_THOUSAND;
            cnfp_pkg::CP_DOT_A, cnfp_pkg::CP_DOT_B: cls.is_dot = 1'b1;
            cnfp_pkg::CP_MINUS:    cls.is_minus = 1'b1;
            default:               cls = '0;
        endcase
    end

endmodule

// File: hdl/cnfp_parse.sv
// parser state: phase, sign, integer sum, held digit, fraction, overflow
// updates once per stepped item and forms the result of a final item
// depends on cnfp_pkg
module cnfp_parse (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     last_char,
    input  cnfp_pkg::cnfp_class_t    cls,
    output cnfp_pkg::cnfp_result_t   result
);

    logic [2:0]                     phase_reg, phase_next;
    logic                           neg_reg, neg_next;
    logic [cnfp_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [3:0]                     held_reg, held_next;
    logic [1:0]                     fcount_reg, fcount_next;
    logic [cnfp_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic                           ovf_reg, ovf_next;

    logic                           numeral;
    logic                           run;
    logic                           in_frac;
    logic [3:0]                     now_digit;
    logic [cnfp_pkg::AMT_W-1:0]     mult_val;
    logic [cnfp_pkg::AMT_W-1:0]     amount;
    logic [cnfp_pkg::AMT_W-1:0]     sum_wide;
    logic [3:0]                     frac_digit;
    logic [cnfp_pkg::SUM_W-1:0]     total;
    logic [cnfp_pkg::MAG_W-1:0]     mag;
    logic [cnfp_pkg::VAL_W-1:0]     mag_ext;

    assign numeral    = cls.is_digit || (cls.mult != cnfp_pkg::MULT_NONE) || cls.is_dot;
    assign now_digit  = (held_reg == 4'd0) ? 4'd1 : held_reg;
    assign frac_digit = cls.is_digit ? cls.digit : 4'd0;

    always_comb
    begin
        unique case (cls.mult)
            cnfp_pkg::MULT_TEN:      mult_val = 14'd10;
            cnfp_pkg::MULT_HUNDRED:  mult_val = 14'd100;
            cnfp_pkg::MULT_THOUSAND: mult_val = 14'd1000;
            default:                 mult_val = 14'd0;
        endcase
    end

    assign amount   = 14'({10'd0, now_digit} * mult_val);
    assign sum_wide = {3'd0, sum_reg} + amount;

    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        sum_next    = sum_reg;
        held_next   = held_reg;
        fcount_next = fcount_reg;
        frac_next   = frac_reg;
        ovf_next    = ovf_reg;
        run         = 1'b0;
        in_frac     = 1'b0;

        unique case (phase_reg)
            cnfp_pkg::PH_SEEK, cnfp_pkg::PH_MINUS:
            begin
                if (numeral)
                begin
                    neg_next   = (phase_reg == cnfp_pkg::PH_MINUS);
                    phase_next = cnfp_pkg::PH_INT;
                    run        = 1'b1;
                end
                else
                begin
                    phase_next = cls.is_minus ? cnfp_pkg::PH_MINUS : cnfp_pkg::PH_SEEK;
                end
            end
            cnfp_pkg::PH_INT, cnfp_pkg::PH_FRAC:
            begin
                if (numeral)
                begin
                    run     = 1'b1;
                    in_frac = (phase_reg == cnfp_pkg::PH_FRAC);
                end
                else
                begin
                    phase_next = cnfp_pkg::PH_DONE;
                end
            end
            default: phase_next = cnfp_pkg::PH_DONE;
        endcase

        if (run && !in_frac)
        begin
            priority if (cls.is_digit)
            begin
                held_next = cls.digit;
            end
            else if (cls.is_dot)
            begin
                phase_next = cnfp_pkg::PH_FRAC;
            end
            else
            begin
                held_next = 4'd0;
                if (sum_wide > {3'd0, cnfp_pkg::INT_LIMIT})
                begin
                    sum_next = cnfp_pkg::SUM_SAT;
                    ovf_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[cnfp_pkg::SUM_W-1:0];
                end
            end
        end
        else if (run)
        begin
            unique case (fcount_reg)
                2'd0:
                begin
                    frac_next   = frac_reg + 7'({3'd0, frac_digit} * 7'd10);
                    fcount_next = 2'd1;
                end
                2'd1:
                begin
                    frac_next   = frac_reg + {3'd0, frac_digit};
                    fcount_next = 2'd2;
                end
                default: fcount_next = fcount_reg;
            endcase
        end
    end

    // result as seen after this item
    assign total   = sum_next + {7'd0, held_next};

    always_comb
    begin
        mag = '0;
        priority if (phase_next == cnfp_pkg::PH_SEEK || phase_next == cnfp_pkg::PH_MINUS)
        begin
            result.status = cnfp_pkg::ST_NONE;
        end
        else if (ovf_next || total > cnfp_pkg::INT_LIMIT)
        begin
            result.status = cnfp_pkg::ST_OVER;
        end
        else
        begin
            result.status = cnfp_pkg::ST_OK;
            mag = 17'({6'd0, total} * 17'd100) + {10'd0, frac_next};
        end
        mag_ext = {1'b0, mag};
        result.value = neg_next ? $signed(18'd0 - mag_ext) : $signed(mag_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cnfp_pkg::PH_SEEK;
            neg_reg    <= 1'b0;
            sum_reg    <= '0;
            held_reg   <= '0;
            fcount_reg <= '0;
            frac_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                phase_reg  <= cnfp_pkg::PH_SEEK;
                neg_reg    <= 1'b0;
                sum_reg    <= '0;
                held_reg   <= '0;
                fcount_reg <= '0;
                frac_reg   <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                sum_reg    <= sum_next;
                held_reg   <= held_next;
                fcount_reg <= fcount_next;
                frac_reg   <= frac_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

// File: hdl/chinese_numeral_to_fixed_point_core.sv
// Parses a stream of Unicode code points, one item per clock, and after the
// item marked last_char delivers one item with the value in hundredths and a
// status. An accepted code point enters an input register, is decoded and
// applied to the parser state when it leaves that register, and a final
// item's result lands in the output register at that same edge. Input is
// taken every cycle; it stalls only while a final item waits behind a
// result that has not yet been taken.
// depends on cnfp_pkg, cnfp_char_if, cnfp_result_if, cnfp_classify, cnfp_parse
module chinese_numeral_to_fixed_point_core (
    input  logic            clk,
    input  logic            rst_n,
    cnfp_char_if.sink       char_stream,
    cnfp_result_if.source   result
);

    logic                           s1_valid_reg;
    logic [cnfp_pkg::CP_W-1:0]      s1_cp_reg;
    logic                           s1_last_reg;
    logic                           out_valid_reg;
    cnfp_pkg::cnfp_result_t         out_reg;

    cnfp_pkg::cnfp_class_t          cls;
    cnfp_pkg::cnfp_result_t         step_result;
    logic                           out_free;
    logic                           s1_fire;
    logic                           out_load;
    logic                           in_ready;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign out_load = s1_fire && s1_last_reg;
    assign in_ready = !s1_valid_reg || s1_fire;

    assign char_stream.ready       = in_ready;
    assign result.valid            = out_valid_reg;
    assign result.value_hundredths = out_reg.value;
    assign result.status           = out_reg.status;

    cnfp_classify u_classify (
        .code_point (s1_cp_reg),
        .cls        (cls)
    );

    cnfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .last_char (s1_last_reg),
        .cls       (cls),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= char_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && char_stream.valid)
        begin
            s1_cp_reg   <= char_stream.code_point;
            s1_last_reg <= char_stream.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= step_result;
        end
    end

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result not presented after final item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == cnfp_pkg::ST_OK
                        || out_reg.status == cnfp_pkg::ST_NONE
                        || out_reg.status == cnfp_pkg::ST_OVER))
        else $error("undefined status code");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != cnfp_pkg::ST_OK) |-> (out_reg.value == '0))
        else $error("nonzero value with failing status");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready))
        else $error("input stalled without a pending final item");

endmodule
